/* rtl/rvgi_pkg.sv */
package rvgi_pkg;

	// geometry: cell edge in fixed point is 2^CELL_FX_BITS (64 pixels, 8 fraction bits)
	localparam int CELL_FX_BITS = 14;
	localparam logic signed [23:0] CELL_FX = 24'sd1 <<< CELL_FX_BITS;
	localparam int GRID_BITS = 6;
	localparam logic [6:0] GRID_MAX = 7'd64;
	localparam int CLEAR_ROWS = 64;

	// tangent limit, iteration counts and distance limit
	localparam logic [22:0] TAN_LIMIT = 23'h7FFFFF;
	localparam int CORDIC_ITERS = 30;
	localparam int DIV_STEPS = 23;
	localparam int SQRT_STEPS = 24;
	localparam logic [20:0] DIST_MAX = 21'h1FFFFF;

	// register indexes
	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS = 1'b1;

	// input kinds
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_CAST = 1'b1;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLEAR,
		OP_WRITE,
		OP_LOAD,
		OP_CORDIC,
		OP_DIV_INIT,
		OP_DIV,
		OP_TAN,
		OP_MUL,
		OP_START,
		OP_READ,
		OP_TEST,
		OP_SQUARE,
		OP_SQINIT,
		OP_SQRT,
		OP_OUT_HIT,
		OP_OUT_MISS
	} op_t;

	typedef struct packed {
		op_t op;
		logic [5:0] iter;
	} cmd_t;

	typedef struct packed {
		logic in_map;
		logic wall;
	} sts_t;

	// arctangent of 2^-i in turns scaled by 2^32
	function automatic logic [29:0] atan_turn(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0: v = 30'd536870912;
			5'd1: v = 30'd316933406;
			5'd2: v = 30'd167458907;
			5'd3: v = 30'd85004756;
			5'd4: v = 30'd42667331;
			5'd5: v = 30'd21354465;
			5'd6: v = 30'd10679838;
			5'd7: v = 30'd5340245;
			5'd8: v = 30'd2670163;
			5'd9: v = 30'd1335087;
			5'd10: v = 30'd667544;
			5'd11: v = 30'd333772;
			5'd12: v = 30'd166886;
			5'd13: v = 30'd83443;
			5'd14: v = 30'd41722;
			5'd15: v = 30'd20861;
			5'd16: v = 30'd10430;
			5'd17: v = 30'd5215;
			5'd18: v = 30'd2608;
			5'd19: v = 30'd1304;
			5'd20: v = 30'd652;
			5'd21: v = 30'd326;
			5'd22: v = 30'd163;
			5'd23: v = 30'd81;
			5'd24: v = 30'd41;
			5'd25: v = 30'd20;
			5'd26: v = 30'd10;
			5'd27: v = 30'd5;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/rvgi_ctrl.sv */
module rvgi_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic action,
	input  logic m_tready,
	input  rvgi_pkg::sts_t sts,
	output logic s_tready,
	output logic m_tvalid,
	output rvgi_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_CORDIC, ST_DIV_INIT, ST_DIV, ST_TAN, ST_MUL, ST_START,
		ST_READ, ST_TEST, ST_SQUARE, ST_SQINIT, ST_SQRT, ST_DONE
	} state_t;

	state_t state_q;
	logic [5:0] cnt_q;
	logic hit_q;
	logic out_valid_q;
	logic out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	// command decode
	always_comb begin
		cmd.iter = cnt_q;
		cmd.op = rvgi_pkg::OP_NONE;
		case (state_q)
			ST_CLEAR: cmd.op = rvgi_pkg::OP_CLEAR;
			ST_IDLE: begin
				if (s_tvalid)
					cmd.op = (action == rvgi_pkg::ACT_CAST) ? rvgi_pkg::OP_LOAD
						: rvgi_pkg::OP_WRITE;
			end
			ST_CORDIC: cmd.op = rvgi_pkg::OP_CORDIC;
			ST_DIV_INIT: cmd.op = rvgi_pkg::OP_DIV_INIT;
			ST_DIV: cmd.op = rvgi_pkg::OP_DIV;
			ST_TAN: cmd.op = rvgi_pkg::OP_TAN;
			ST_MUL: cmd.op = rvgi_pkg::OP_MUL;
			ST_START: cmd.op = rvgi_pkg::OP_START;
			ST_READ: begin
				if (sts.in_map)
					cmd.op = rvgi_pkg::OP_READ;
			end
			ST_TEST: cmd.op = rvgi_pkg::OP_TEST;
			ST_SQUARE: cmd.op = rvgi_pkg::OP_SQUARE;
			ST_SQINIT: cmd.op = rvgi_pkg::OP_SQINIT;
			ST_SQRT: cmd.op = rvgi_pkg::OP_SQRT;
			ST_DONE: begin
				if (out_free)
					cmd.op = hit_q ? rvgi_pkg::OP_OUT_HIT : rvgi_pkg::OP_OUT_MISS;
			end
			default: cmd.op = rvgi_pkg::OP_NONE;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			hit_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(rvgi_pkg::CLEAR_ROWS - 1)) begin
						cnt_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid && action == rvgi_pkg::ACT_CAST) begin
						cnt_q <= '0;
						state_q <= ST_CORDIC;
					end
				end
				ST_CORDIC: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(rvgi_pkg::CORDIC_ITERS - 1))
						state_q <= ST_DIV_INIT;
				end
				ST_DIV_INIT: begin
					cnt_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(rvgi_pkg::DIV_STEPS - 1))
						state_q <= ST_TAN;
				end
				ST_TAN: state_q <= ST_MUL;
				ST_MUL: state_q <= ST_START;
				ST_START: state_q <= ST_READ;
				ST_READ: begin
					if (sts.in_map) begin
						state_q <= ST_TEST;
					end else begin
						hit_q <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_TEST: state_q <= sts.wall ? ST_SQUARE : ST_READ;
				ST_SQUARE: state_q <= ST_SQINIT;
				ST_SQINIT: begin
					cnt_q <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(rvgi_pkg::SQRT_STEPS - 1)) begin
						hit_q <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/rvgi_dpath.sv */
module rvgi_dpath (
	input  logic clk,
	input  rvgi_pkg::cmd_t cmd,
	output rvgi_pkg::sts_t sts,
	input  logic [6:0] cols,
	input  logic [6:0] rows,
	input  logic [5:0] cell_column,
	input  logic [5:0] cell_row,
	input  logic cell_is_wall,
	input  logic [19:0] player_x,
	input  logic [19:0] player_y,
	input  logic [11:0] angle,
	input  logic facing_right,
	input  logic facing_down,
	output logic hit,
	output logic [19:0] hit_x,
	output logic [19:0] hit_y,
	output logic [20:0] hit_distance
);

	logic [63:0] grid_mem [rvgi_pkg::CLEAR_ROWS];

	// cast operands
	logic [19:0] px_q, py_q;
	logic right_q, down_q, neg_q, special_q;
	// cordic
	logic signed [31:0] x_q, y_q;
	logic signed [33:0] z_q;
	// divider
	logic [46:0] rem_q;
	logic [53:0] dsh_q;
	logic [22:0] quo_q;
	logic sat_q, ysgn_q;
	// walk
	logic signed [23:0] t_q, xi_q, yi_q, ystep_q;
	logic signed [15:0] diff_q;
	logic signed [39:0] prod_q;
	logic [63:0] row_q;
	logic [5:0] col_q;
	logic colneg_q;
	// distance
	logic [45:0] dx2_q, dy2_q;
	logic [47:0] n_q, res_q, bit_q;

	logic [10:0] a_half;
	logic [10:0] a_fold;
	logic [4:0] it;
	logic signed [31:0] xsh, ysh;
	logic signed [33:0] at;
	logic [30:0] ymag;
	logic [46:0] dvd;
	logic [53:0] dlim;
	logic [53:0] trial;
	logic [22:0] tmag;
	logic signed [23:0] tsgn, tq4, tq4_abs, xi0, dxs, dys;
	logic [22:0] dx_abs, dy_abs;
	logic [47:0] sq_sum, rb;
	logic [20:0] xlim, ylim;

	assign it = cmd.iter[4:0];
	assign a_half = {1'b0, angle[9:0]} | {angle[10], 10'b0};
	assign a_fold = (a_half > 11'd1024) ? 11'(12'd2048 - {1'b0, a_half}) : a_half;
	assign xsh = y_q >>> it;
	assign ysh = x_q >>> it;
	assign at = 34'(rvgi_pkg::atan_turn(it));
	assign ymag = y_q[31] ? 31'(-y_q) : y_q[30:0];
	assign dvd = {ymag[30:0], 16'b0};
	assign dlim = {x_q[30:0], 23'b0};
	assign trial = {7'b0, rem_q} - dsh_q;
	assign tmag = sat_q ? rvgi_pkg::TAN_LIMIT : quo_q;
	assign tsgn = (ysgn_q ^ neg_q) ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
	assign tq4 = t_q >>> 2;
	assign tq4_abs = tq4[23] ? -tq4 : tq4;
	assign xi0 = $signed({4'b0, player_x[19:rvgi_pkg::CELL_FX_BITS],
		{rvgi_pkg::CELL_FX_BITS{1'b0}}}) + (facing_right ? rvgi_pkg::CELL_FX : 24'sd0);
	assign dxs = xi_q - $signed({4'b0, px_q});
	assign dys = yi_q - $signed({4'b0, py_q});
	assign dx_abs = dxs[23] ? 23'(-dxs) : dxs[22:0];
	assign dy_abs = dys[23] ? 23'(-dys) : dys[22:0];
	assign sq_sum = {2'b0, dx2_q} + {2'b0, dy2_q};
	assign rb = res_q + bit_q;
	assign xlim = {(cols > rvgi_pkg::GRID_MAX) ? rvgi_pkg::GRID_MAX : cols,
		{rvgi_pkg::CELL_FX_BITS{1'b0}}};
	assign ylim = {(rows > rvgi_pkg::GRID_MAX) ? rvgi_pkg::GRID_MAX : rows,
		{rvgi_pkg::CELL_FX_BITS{1'b0}}};

	// loop bounds and wall test
	assign sts.in_map = !xi_q[23] && !yi_q[23]
		&& (xi_q[22:0] < {2'b0, xlim}) && (yi_q[22:0] < {2'b0, ylim});
	assign sts.wall = colneg_q || row_q[col_q];

	// map store: clear pass, cell writes, row reads
	always_ff @(posedge clk) begin
		case (cmd.op)
			rvgi_pkg::OP_CLEAR: grid_mem[cmd.iter] <= '0;
			rvgi_pkg::OP_WRITE: grid_mem[cell_row][cell_column] <= cell_is_wall;
			rvgi_pkg::OP_READ: row_q <= grid_mem[yi_q[19:rvgi_pkg::CELL_FX_BITS]];
			default: ;
		endcase
	end

	// arithmetic datapath
	always_ff @(posedge clk) begin
		case (cmd.op)
			rvgi_pkg::OP_LOAD: begin
				px_q <= player_x;
				py_q <= player_y;
				right_q <= facing_right;
				down_q <= facing_down;
				neg_q <= a_half > 11'd1024;
				special_q <= a_half == 11'd1024;
				x_q <= 32'sd536870912;
				y_q <= '0;
				z_q <= $signed({3'b0, a_fold, 20'b0});
				xi_q <= xi0;
				diff_q <= 16'(xi0 - $signed({4'b0, player_x}));
			end
			rvgi_pkg::OP_CORDIC: begin
				if (!z_q[33]) begin
					x_q <= x_q - xsh;
					y_q <= y_q + ysh;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + xsh;
					y_q <= y_q - ysh;
					z_q <= z_q + at;
				end
			end
			rvgi_pkg::OP_DIV_INIT: begin
				rem_q <= dvd;
				dsh_q <= {1'b0, x_q[30:0], 22'b0};
				quo_q <= '0;
				if (special_q || x_q[31] || x_q == 32'sd0) begin
					sat_q <= 1'b1;
					ysgn_q <= 1'b0;
				end else begin
					sat_q <= {7'b0, dvd} >= dlim;
					ysgn_q <= y_q[31];
				end
			end
			rvgi_pkg::OP_DIV: begin
				if (!trial[53]) begin
					rem_q <= trial[46:0];
					quo_q <= {quo_q[21:0], 1'b1};
				end else begin
					quo_q <= {quo_q[21:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
			rvgi_pkg::OP_TAN: t_q <= tsgn;
			rvgi_pkg::OP_MUL: begin
				prod_q <= diff_q * t_q;
				ystep_q <= down_q ? tq4_abs : -tq4_abs;
			end
			rvgi_pkg::OP_START: yi_q <= $signed({4'b0, py_q}) + prod_q[39:16];
			rvgi_pkg::OP_READ: begin
				colneg_q <= !right_q && xi_q[19:rvgi_pkg::CELL_FX_BITS] == 6'd0;
				col_q <= right_q ? xi_q[19:rvgi_pkg::CELL_FX_BITS]
					: xi_q[19:rvgi_pkg::CELL_FX_BITS] - 6'd1;
			end
			rvgi_pkg::OP_TEST: begin
				if (!sts.wall) begin
					xi_q <= right_q ? xi_q + rvgi_pkg::CELL_FX : xi_q - rvgi_pkg::CELL_FX;
					yi_q <= yi_q + ystep_q;
				end
			end
			rvgi_pkg::OP_SQUARE: begin
				dx2_q <= dx_abs * dx_abs;
				dy2_q <= dy_abs * dy_abs;
			end
			rvgi_pkg::OP_SQINIT: begin
				n_q <= sq_sum;
				res_q <= '0;
				bit_q <= 48'h4000_0000_0000;
			end
			rvgi_pkg::OP_SQRT: begin
				if (n_q >= rb) begin
					n_q <= n_q - rb;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			default: ;
		endcase
	end

	// output word register
	always_ff @(posedge clk) begin
		case (cmd.op)
			rvgi_pkg::OP_OUT_HIT: begin
				hit <= 1'b1;
				hit_x <= xi_q[19:0];
				hit_y <= yi_q[19:0];
				hit_distance <= (res_q[47:21] != '0) ? rvgi_pkg::DIST_MAX : res_q[20:0];
			end
			rvgi_pkg::OP_OUT_MISS: begin
				hit <= 1'b0;
				hit_x <= '0;
				hit_y <= '0;
				hit_distance <= '0;
			end
			default: ;
		endcase
	end

endmodule

/* rtl/ray_vertical_grid_intersect.sv */
// per cast: the 30-step cordic, the 23-step tangent divider, then for each vertical grid line
//   tested (up to 64) a map row read and a test, and on a hit the 24-step square root; the
//   result word is held back while the previous word is still held by the receiver
// a map write item is done in the cycle it is taken; one item is worked on at a time
// reset: async, active low; a clearing pass over all 64 rows empties the map, sizes reset to 64
module ray_vertical_grid_intersect (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// col[5:0], row[11:6], wall[12], player_x[32:13], player_y[52:33],
	// angle[64:53], facing_right[65], facing_down[66], zero fill
	input  logic [71:0] s_tdata,
	// action[0]
	input  logic s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// hit[0], hit_x[20:1], hit_y[40:21], hit_distance[61:41], zero fill
	output logic [63:0] m_tdata,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [2:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	logic [6:0] cols_q, rows_q;
	rvgi_pkg::cmd_t cmd;
	rvgi_pkg::sts_t sts;
	logic hit;
	logic [19:0] hit_x, hit_y;
	logic [20:0] hit_distance;

	// config registers
	assign pready = 1'b1;
	assign prdata = {25'b0, (paddr[2] == rvgi_pkg::REG_ROWS) ? rows_q : cols_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 7'd64;
			rows_q <= 7'd64;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == rvgi_pkg::REG_COLUMNS)
				cols_q <= pwdata[6:0];
			else
				rows_q <= pwdata[6:0];
		end
	end

	rvgi_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.action(s_tuser),
		.m_tready(m_tready),
		.sts(sts),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.cmd(cmd)
	);

	rvgi_dpath u_dpath (
		.clk(clk),
		.cmd(cmd),
		.sts(sts),
		.cols(cols_q),
		.rows(rows_q),
		.cell_column(s_tdata[5:0]),
		.cell_row(s_tdata[11:6]),
		.cell_is_wall(s_tdata[12]),
		.player_x(s_tdata[32:13]),
		.player_y(s_tdata[52:33]),
		.angle(s_tdata[64:53]),
		.facing_right(s_tdata[65]),
		.facing_down(s_tdata[66]),
		.hit(hit),
		.hit_x(hit_x),
		.hit_y(hit_y),
		.hit_distance(hit_distance)
	);

	assign m_tdata = {2'b0, hit_distance, hit_y, hit_x, hit};

endmodule

/* rtl/rvgi_chk.sv */
module rvgi_chk (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic s_tuser,
	input logic m_tvalid,
	input logic m_tready,
	input logic [63:0] m_tdata
);

	// held word stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed while stalled");

	// a miss carries no point and no distance
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[61:1] == '0)
		else $error("miss word has nonzero fields");

	// a hit lies on a vertical grid line
	a_on_line: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[14:1] == '0)
		else $error("hit x off grid line");

	// a map write finishes in the cycle it is taken
	a_write_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser |=> s_tready)
		else $error("map write stalled the input");

endmodule

bind ray_vertical_grid_intersect rvgi_chk u_rvgi_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser(s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
